FILE: sv/ssdp_pkg.sv
// Shared types and constants for the size-suffix decimal parser.
// No dependencies; used by ssdp_step and size_suffix_decimal_parser_core.
`default_nettype none

package ssdp_pkg;

  // Parse phase codes
  localparam logic [1:0] PHASE_START  = 2'd0;
  localparam logic [1:0] PHASE_DIGITS = 2'd1;
  localparam logic [1:0] PHASE_SUFFIX = 2'd2;
  localparam logic [1:0] PHASE_FAILED = 2'd3;

  // Value format codes (the fourth code behaves as unsigned 64-bit)
  localparam logic [1:0] FMT_S32 = 2'd0;
  localparam logic [1:0] FMT_U32 = 2'd1;
  localparam logic [1:0] FMT_U64 = 2'd2;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned CHAR_W  = 8;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Per-string parser state
  typedef struct packed {
    logic [VALUE_W-1:0] acc;
    logic [1:0]         phase;
    logic               neg;
  } parse_state_t;

endpackage

`default_nettype wire

FILE: sv/ssdp_step.sv
// Next-state logic of the parser for one non-terminator byte.
// Depends on ssdp_pkg for the state type and the phase and format codes.
`default_nettype none

module ssdp_step (
  input  wire logic [7:0]          char_code,
  input  wire logic [1:0]          value_format,
  input  wire ssdp_pkg::parse_state_t cur,
  output ssdp_pkg::parse_state_t   nxt
);

  logic                            is_digit;
  logic [3:0]                      digit;
  logic [ssdp_pkg::VALUE_W-1:0]    acc_times_ten;
  logic [ssdp_pkg::VALUE_W-1:0]    acc_shifted;
  logic                            is_suffix;
  logic                            wide;

  assign wide     = (value_format >= ssdp_pkg::FMT_U64);
  assign is_digit = (char_code >= ssdp_pkg::CH_ZERO) && (char_code <= ssdp_pkg::CH_NINE);
  assign digit    = 4'(char_code - ssdp_pkg::CH_ZERO);

  // acc*10 + digit as (acc<<3) + (acc<<1) + digit, wrapping at 64 bits
  assign acc_times_ten = {cur.acc[ssdp_pkg::VALUE_W-4:0], 3'b000}
                       + {cur.acc[ssdp_pkg::VALUE_W-2:0], 1'b0}
                       + {{(ssdp_pkg::VALUE_W-4){1'b0}}, digit};

  // Pick the suffix shift; t and p only count in the wide format
  always_comb begin
    acc_shifted = cur.acc;
    is_suffix   = 1'b0;
    unique case (char_code)
      8'h6b, 8'h4b: begin
        acc_shifted = cur.acc << 10;
        is_suffix   = 1'b1;
      end
      8'h6d, 8'h4d: begin
        acc_shifted = cur.acc << 20;
        is_suffix   = 1'b1;
      end
      8'h67, 8'h47: begin
        acc_shifted = cur.acc << 30;
        is_suffix   = 1'b1;
      end
      8'h74, 8'h54: begin
        acc_shifted = cur.acc << 40;
        is_suffix   = wide;
      end
      8'h70, 8'h50: begin
        acc_shifted = cur.acc << 50;
        is_suffix   = wide;
      end
      default: begin
        acc_shifted = cur.acc;
        is_suffix   = 1'b0;
      end
    endcase
  end

  // Advance the phase; order of checks decides
  always_comb begin
    nxt = cur;
    priority if (cur.phase == ssdp_pkg::PHASE_FAILED) begin
      nxt = cur;
    end else if (cur.phase == ssdp_pkg::PHASE_SUFFIX) begin
      nxt.phase = ssdp_pkg::PHASE_FAILED;
    end else if (cur.phase == ssdp_pkg::PHASE_START && char_code == ssdp_pkg::CH_MINUS
                 && value_format == ssdp_pkg::FMT_S32) begin
      nxt.neg   = 1'b1;
      nxt.phase = ssdp_pkg::PHASE_DIGITS;
    end else if (is_digit) begin
      nxt.acc   = acc_times_ten;
      nxt.phase = ssdp_pkg::PHASE_DIGITS;
    end else if (is_suffix) begin
      nxt.acc   = acc_shifted;
      nxt.phase = ssdp_pkg::PHASE_SUFFIX;
    end else begin
      nxt.phase = ssdp_pkg::PHASE_FAILED;
    end
  end

endmodule

`default_nettype wire

FILE: sv/size_suffix_decimal_parser_core.sv
// Top level of the size-suffix decimal parser: handshakes, state and result registers.
// Depends on ssdp_pkg and ssdp_step.
`default_nettype none

// Parses a NUL-terminated decimal string fed one byte per transfer, with an
// optional k/m/g (and t/p in unsigned 64-bit format) binary suffix and, in
// signed 32-bit format, a leading minus. The per-byte update (multiply by
// ten and add, or a constant suffix shift) is applied to the state registers
// at the input transfer, and the NUL byte loads the result register at its
// own transfer, so the masked, sign-applied value and fail flag are offered
// in the next cycle. Bytes are taken every cycle; only a NUL byte waits,
// and only while the previous result is still held by a stalled output.
// Write cfg_value_format only while no string is in progress.
module size_suffix_decimal_parser_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_value_format,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_code,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_value,
  output logic             out_failed
);

  logic [1:0]              fmt_r;
  ssdp_pkg::parse_state_t  st_r;
  ssdp_pkg::parse_state_t  st_nxt;
  ssdp_pkg::parse_state_t  step_nxt;
  logic                    out_valid_r;
  logic [63:0]             out_value_r;
  logic                    out_failed_r;
  logic                    in_fire;
  logic                    is_nul;
  logic [63:0]             res_value;
  logic                    res_failed;

  assign is_nul   = (in_char_code == ssdp_pkg::CH_NUL);
  // Hold a terminator while the previous result is still waiting
  assign in_stall = out_valid_r && out_stall && is_nul;
  assign in_fire  = in_valid && !in_stall;

  ssdp_step u_step (
    .char_code    (in_char_code),
    .value_format (fmt_r),
    .cur          (st_r),
    .nxt          (step_nxt)
  );

  // Form the result from the current state
  always_comb begin
    res_failed = (st_r.phase == ssdp_pkg::PHASE_FAILED);
    res_value  = st_r.acc;
    if (fmt_r == ssdp_pkg::FMT_S32 && st_r.neg) begin
      res_value = 64'd0 - st_r.acc;
    end
    if (fmt_r == ssdp_pkg::FMT_S32 || fmt_r == ssdp_pkg::FMT_U32) begin
      res_value = {32'd0, res_value[31:0]};
    end
    if (res_failed) begin
      res_value = 64'd0;
    end
  end

  // Rearm on the terminator, otherwise take the step result
  always_comb begin
    st_nxt = st_r;
    if (in_fire) begin
      if (is_nul) begin
        st_nxt.acc   = 64'd0;
        st_nxt.phase = ssdp_pkg::PHASE_START;
        st_nxt.neg   = 1'b0;
      end else begin
        st_nxt = step_nxt;
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= ssdp_pkg::FMT_S32;
    end else if (cfg_we) begin
      fmt_r <= cfg_value_format;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.acc   <= 64'd0;
      st_r.phase <= ssdp_pkg::PHASE_START;
      st_r.neg   <= 1'b0;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Result register: load on terminator transfer, drop on output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && is_nul) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_nul) begin
      out_value_r  <= res_value;
      out_failed_r <= res_failed;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_failed = out_failed_r;

  // A terminator transfer rearms the parser
  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_nul |=> st_r.phase == ssdp_pkg::PHASE_START && st_r.acc == 64'd0 && !st_r.neg)
    else $error("parser not rearmed after terminator");

  // A terminator transfer always produces a result
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_nul |=> out_valid_r)
    else $error("terminator produced no result");

  // A failed result carries a zero value
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_failed_r |-> out_value_r == 64'd0)
    else $error("failed result with nonzero value");

  // The sign flag is only set once parsing has left the start phase
  a_neg_phase: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.neg |-> st_r.phase != ssdp_pkg::PHASE_START)
    else $error("negative flag set at start of string");

endmodule

`default_nettype wire
